FILE: design/pfba_pkg.sv
// Package for the physical frame bitmap allocator.
// Holds operation codes, result status codes, the engine state type,
// the config register map and the bit-search helpers. No dependencies.
package pfba_pkg;

  // Operation codes on the input channel
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Config register map: one register, index taken from paddr[2]
  localparam int unsigned CFG_AW          = 3;
  localparam logic        REG_REGION_BASE = 1'b0;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  // Engine sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ALLOC_WR,
    S_FREE_CHK,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } eng_state_t;

  // One-hot of the lowest clear bit in a word (zero if the word is all ones)
  function automatic logic [31:0] lowest_zero_onehot(input logic [31:0] w);
    return ~w & (w + 32'h1);
  endfunction

  // Encode a one-hot word into its bit position
  function automatic logic [4:0] onehot_index(input logic [31:0] oh);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (oh[i]) begin
        idx = idx | 5'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: design/physical_frame_bitmap_allocator_core.sv
// Top level of the first-fit physical frame allocator.
// Depends on pfba_pkg, pfba_map_ram, pfba_cfg_regs and pfba_engine.
//
//   channel  | ports                                               | handshake
//   ---------+-----------------------------------------------------+--------------------
//   input    | in_operation, in_frame_address                      | in_valid/in_ready
//   result   | out_granted_address, out_status, out_free_frames    | out_valid/out_ready
//   config   | psel, penable, pwrite, paddr, pwdata, prdata        | pready tied high
//
// One item is in work at a time; in_ready rises in the cycle after a result is loaded.
// Allocate: the scan reads one bitmap word per cycle until it finds the lowest free
// frame, then that word is written back. Allocate with no free frame skips the scan.
// Free: range check, RAM read, write back, result; out of range goes from check to result.
// After reset a clearing pass writes MAP_WORDS words, one per cycle, before in_ready rises.
// A stalled result waits in the output register while the next item is taken and run.
module physical_frame_bitmap_allocator_core #(
  parameter int unsigned FRAMES     = 1024,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [31:0]                 in_frame_address,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_granted_address,
  output logic [1:0]                  out_status,
  output logic [10:0]                 out_free_frames,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfba_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned MAP_WORDS = (FRAMES + 31) / 32;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  logic [31:0]        region_base;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [31:0]        mem_rdata;
  pfba_pkg::status_t  eng_status;

  pfba_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .region_base (region_base)
  );

  pfba_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pfba_engine #(
    .FRAMES     (FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .MAP_WORDS  (MAP_WORDS),
    .AW         (AW)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .region_base         (region_base),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_frame_address    (in_frame_address),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_granted_address (out_granted_address),
    .out_status          (eng_status),
    .out_free_frames     (out_free_frames),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .mem_re              (mem_re),
    .mem_raddr           (mem_raddr),
    .mem_rdata           (mem_rdata)
  );

  assign out_status = eng_status;

endmodule

FILE: design/pfba_map_ram.sv
// Bitmap RAM of the frame allocator: one write port, one read port,
// read data registered. No package dependencies.
module pfba_map_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/pfba_cfg_regs.sv
// APB-style config register block of the frame allocator: region_base.
// Depends on pfba_pkg for the register map.
module pfba_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfba_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [31:0]                 region_base
);

  logic [31:0] region_base_r;
  logic        wr_hit;

  // Decode a write transfer to the region base register
  assign wr_hit = psel && penable && pwrite && (paddr[2] == pfba_pkg::REG_REGION_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
    end else if (wr_hit) begin
      region_base_r <= pwdata;
    end
  end

  // Read back; unmapped addresses read zero
  always_comb begin
    if (paddr[2] == pfba_pkg::REG_REGION_BASE) begin
      prdata = region_base_r;
    end else begin
      prdata = '0;
    end
  end

  assign pready      = 1'b1;
  assign region_base = region_base_r;

endmodule

FILE: design/pfba_engine.sv
// Allocation engine: clearing pass, first-fit scan, free read-modify-write,
// free count and the output register. Depends on pfba_pkg; drives pfba_map_ram.
module pfba_engine #(
  parameter int unsigned FRAMES     = 1024,
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned MAP_WORDS  = 32,
  parameter int unsigned AW         = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [31:0]             region_base,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_operation,
  input  logic [31:0]             in_frame_address,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [31:0]             out_granted_address,
  output pfba_pkg::status_t       out_status,
  output logic [10:0]             out_free_frames,
  // bitmap RAM
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [31:0]             mem_wdata,
  output logic                    mem_re,
  output logic [AW-1:0]           mem_raddr,
  input  logic [31:0]             mem_rdata
);

  localparam int unsigned   CNT_W     = $clog2(FRAMES + 1);
  localparam int unsigned   TAIL_BITS = FRAMES % 32;
  localparam logic [31:0]   TAIL_MASK = (TAIL_BITS == 0) ? 32'h0 :
                                        ~((32'h1 << TAIL_BITS) - 32'h1);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  pfba_pkg::eng_state_t state_r, state_nxt;

  // control
  logic [AW-1:0]    ptr_r;
  logic             issue_done_r;
  logic             chk_vld_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_vld_r;

  // payload
  logic [AW-1:0]      chk_addr_r;
  logic [31:0]        addr_r;
  logic [AW-1:0]      hit_addr_r;
  logic [4:0]         hit_bit_r;
  logic [31:0]        hit_word_r;
  logic [31:0]        hit_oh_r;
  logic [AW-1:0]      fr_word_r;
  logic [4:0]         fr_bit_r;
  logic [31:0]        res_addr_r;
  pfba_pkg::status_t  res_stat_r;
  logic [31:0]        out_addr_r;
  pfba_pkg::status_t  out_stat_r;
  logic [10:0]        out_free_r;

  // combinational helpers
  logic               in_xfer;
  logic               out_load;
  logic [31:0]        scan_word;
  logic [31:0]        scan_oh;
  logic               scan_hit;
  logic               scan_end;
  logic [31:0]        diff;
  logic [31:0]        fidx;
  logic               fr_range_bad;
  logic               fr_bit_set;
  logic [31:0]        grant_addr;
  logic [CNT_W+10:0]  cnt_ext;

  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == pfba_pkg::S_RESP) && (!out_vld_r || out_ready);

  // Scan check on the word returned by the RAM; tail frames past FRAMES read as used
  always_comb begin
    scan_word = mem_rdata | ((chk_addr_r == LAST_WORD) ? TAIL_MASK : 32'h0);
    scan_oh   = pfba_pkg::lowest_zero_onehot(scan_word);
    scan_hit  = chk_vld_r && (scan_word != 32'hFFFF_FFFF);
    scan_end  = chk_vld_r && !scan_hit && (chk_addr_r == LAST_WORD);
  end

  // Free address decode and range check, and the granted address
  always_comb begin
    diff         = addr_r - region_base;
    fidx         = diff >> PAGE_SHIFT;
    fr_range_bad = (addr_r < region_base) || (fidx >= 32'(FRAMES));
    fr_bit_set   = mem_rdata[fr_bit_r];
    grant_addr   = region_base + (32'({hit_addr_r, hit_bit_r}) << PAGE_SHIFT);
    cnt_ext      = {11'b0, cnt_r};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfba_pkg::S_CLEAR: begin
        if (ptr_r == LAST_WORD) state_nxt = pfba_pkg::S_IDLE;
      end
      pfba_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_operation == pfba_pkg::OP_FREE) begin
            state_nxt = pfba_pkg::S_FREE_CHK;
          end else if (cnt_r == '0) begin
            state_nxt = pfba_pkg::S_RESP;
          end else begin
            state_nxt = pfba_pkg::S_SCAN;
          end
        end
      end
      pfba_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_nxt = pfba_pkg::S_ALLOC_WR;
        end else if (scan_end) begin
          state_nxt = pfba_pkg::S_RESP;
        end
      end
      pfba_pkg::S_ALLOC_WR: state_nxt = pfba_pkg::S_RESP;
      pfba_pkg::S_FREE_CHK: begin
        state_nxt = fr_range_bad ? pfba_pkg::S_RESP : pfba_pkg::S_FREE_RD;
      end
      pfba_pkg::S_FREE_RD:  state_nxt = pfba_pkg::S_FREE_WR;
      pfba_pkg::S_FREE_WR:  state_nxt = pfba_pkg::S_RESP;
      pfba_pkg::S_RESP: begin
        if (out_load) state_nxt = pfba_pkg::S_IDLE;
      end
      default: state_nxt = pfba_pkg::S_CLEAR;
    endcase
  end

  // Outputs: handshake and RAM port control
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = 32'h0;
    mem_re    = 1'b0;
    mem_raddr = ptr_r;
    case (state_r)
      pfba_pkg::S_CLEAR: begin
        mem_we = 1'b1;
      end
      pfba_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      pfba_pkg::S_SCAN: begin
        mem_re = !issue_done_r;
      end
      pfba_pkg::S_ALLOC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hit_addr_r;
        mem_wdata = hit_word_r | hit_oh_r;
      end
      pfba_pkg::S_FREE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = fr_word_r;
      end
      pfba_pkg::S_FREE_WR: begin
        mem_we    = fr_bit_set;
        mem_waddr = fr_word_r;
        mem_wdata = mem_rdata & ~(32'h1 << fr_bit_r);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfba_pkg::S_CLEAR;
      ptr_r        <= '0;
      issue_done_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      cnt_r        <= CNT_W'(FRAMES);
      out_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        pfba_pkg::S_CLEAR: begin
          ptr_r <= (ptr_r == LAST_WORD) ? '0 : ptr_r + 1'b1;
        end
        pfba_pkg::S_IDLE: begin
          ptr_r        <= '0;
          issue_done_r <= 1'b0;
          chk_vld_r    <= 1'b0;
        end
        pfba_pkg::S_SCAN: begin
          // advance the read pointer one word a cycle until the last word is issued
          chk_vld_r <= !issue_done_r;
          if (!issue_done_r) begin
            if (ptr_r == LAST_WORD) begin
              issue_done_r <= 1'b1;
            end else begin
              ptr_r <= ptr_r + 1'b1;
            end
          end
        end
        pfba_pkg::S_ALLOC_WR: begin
          cnt_r <= cnt_r - 1'b1;
        end
        pfba_pkg::S_FREE_WR: begin
          if (fr_bit_set) cnt_r <= cnt_r + 1'b1;
        end
        default: begin
        end
      endcase
      // output register: load on a finished item, drop on transfer
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_addr_r <= ptr_r;
    case (state_r)
      pfba_pkg::S_IDLE: begin
        addr_r     <= in_frame_address;
        res_addr_r <= 32'h0;
        res_stat_r <= (in_operation == pfba_pkg::OP_ALLOC && cnt_r == '0) ?
                      pfba_pkg::STAT_NO_FREE : pfba_pkg::STAT_OK;
      end
      pfba_pkg::S_SCAN: begin
        hit_addr_r <= chk_addr_r;
        hit_bit_r  <= pfba_pkg::onehot_index(scan_oh);
        hit_word_r <= mem_rdata;
        hit_oh_r   <= scan_oh;
        if (scan_end) res_stat_r <= pfba_pkg::STAT_NO_FREE;
      end
      pfba_pkg::S_ALLOC_WR: begin
        res_addr_r <= grant_addr;
        res_stat_r <= pfba_pkg::STAT_OK;
      end
      pfba_pkg::S_FREE_CHK: begin
        fr_word_r  <= fidx[5 +: AW];
        fr_bit_r   <= fidx[4:0];
        res_stat_r <= fr_range_bad ? pfba_pkg::STAT_RANGE : pfba_pkg::STAT_OK;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_addr_r <= res_addr_r;
      out_stat_r <= res_stat_r;
      out_free_r <= cnt_ext[10:0];
    end
  end

  assign out_valid           = out_vld_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_stat_r;
  assign out_free_frames     = out_free_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAMES))
    else $error("free count above frame total");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_hit_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pfba_pkg::S_ALLOC_WR |-> 32'({hit_addr_r, hit_bit_r}) < 32'(FRAMES))
    else $error("allocated frame beyond region");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stat_r == pfba_pkg::STAT_NO_FREE |-> out_free_r == 11'd0)
    else $error("no-free result with frames left");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stat_r != pfba_pkg::STAT_OK |-> out_addr_r == 32'h0)
    else $error("failed request carries an address");
`endif

endmodule

FILE: verif/pfba_reply_checker.sv
// Reply checker for the physical frame bitmap allocator: keeps its own bitmap,
// free count and region base, and compares every reply with the prediction.
// Depends on pfba_pkg for the operation, status and register codes.
module pfba_reply_checker #(
  parameter int unsigned FRAMES     = 1024,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_operation,
  input  logic [31:0]                 in_frame_address,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [31:0]                 out_granted_address,
  input  logic [1:0]                  out_status,
  input  logic [10:0]                 out_free_frames,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfba_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          pending_results,
  output int                          mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CFG_W = pfba_pkg::CFG_AW;

  typedef struct packed {
    logic [31:0]       granted;
    pfba_pkg::status_t status;
    logic [10:0]       free_frames;
  } frame_reply_t;

  logic [FRAMES-1:0] used_map;
  int unsigned       free_left;
  logic [31:0]       base_reg;
  frame_reply_t      predicted_replies[$];

  // Serve one request against the local bitmap and return the reply it should give
  function automatic frame_reply_t serve_request(input logic op, input logic [31:0] addr);
    frame_reply_t reply;
    int unsigned  idx;
    logic         found;
    logic [31:0]  span;
    reply.granted = '0;
    reply.status  = pfba_pkg::STAT_OK;
    idx   = 0;
    found = 1'b0;
    if (op == pfba_pkg::OP_ALLOC) begin
      // first fit: lowest clear bit wins
      for (int i = 0; i < FRAMES; i++) begin
        if (!found && !used_map[i]) begin
          found = 1'b1;
          idx   = i;
        end
      end
      if (found) begin
        used_map[idx] = 1'b1;
        if (free_left > 0) free_left--;
        reply.granted = base_reg + 32'(idx << PAGE_SHIFT);
      end else begin
        reply.status = pfba_pkg::STAT_NO_FREE;
      end
    end else if (addr < base_reg) begin
      reply.status = pfba_pkg::STAT_RANGE;
    end else begin
      // frame index truncates any offset inside the page
      span = (addr - base_reg) >> PAGE_SHIFT;
      if (span >= FRAMES) begin
        reply.status = pfba_pkg::STAT_RANGE;
      end else if (used_map[span]) begin
        used_map[span] = 1'b0;
        free_left++;
      end
    end
    reply.free_frames = 11'(free_left);
    return reply;
  endfunction

  always @(posedge clk) begin : watch
    frame_reply_t want;
    int           bad;
    if (!rst_n) begin
      used_map   = '0;
      free_left  = FRAMES;
      base_reg   = '0;
      predicted_replies.delete();
      pending_results <= 0;
      mismatches      <= 0;
    end else begin
      bad = 0;
      // track register writes; only the region base decodes
      if (psel && penable && pwrite && pready &&
          ((paddr >> 2) == CFG_W'(pfba_pkg::REG_REGION_BASE))) begin
        base_reg = pwdata;
      end
      // compare a reply transfer with the oldest prediction
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          $error("reply with no request outstanding: granted %h status %0d free %0d",
                 out_granted_address, out_status, out_free_frames);
          bad++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_granted_address !== want.granted) begin
            $error("out_granted_address: expected %h, got %h", want.granted, out_granted_address);
            bad++;
          end
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            bad++;
          end
          if (out_free_frames !== want.free_frames) begin
            $error("out_free_frames: expected %0d, got %0d", want.free_frames, out_free_frames);
            bad++;
          end
        end
      end
      // predict the reply of a request transfer
      if (in_valid && in_ready) begin
        predicted_replies.push_back(serve_request(in_operation, in_frame_address));
      end
      pending_results <= predicted_replies.size();
      mismatches      <= mismatches + bad;
    end
  end

endmodule

FILE: verif/tb.sv
// Top of the frame allocator testbench: clock, reset, request and register
// stimulus, reply sink and verdict. Depends on pfba_pkg, the allocator core
// and pfba_reply_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAMES        = 1024;
  localparam int unsigned PAGE_SHIFT    = 12;
  localparam int unsigned PAGE_BYTES    = 1 << PAGE_SHIFT;
  localparam logic [31:0] REGION_BYTES  = 32'(FRAMES << PAGE_SHIFT);
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int unsigned CFG_W         = pfba_pkg::CFG_AW;
  localparam logic [CFG_W-1:0] REGION_BASE_ADDR = CFG_W'({pfba_pkg::REG_REGION_BASE, 2'b00});
  localparam logic [CFG_W-1:0] SPARE_REG_ADDR   = CFG_W'({~pfba_pkg::REG_REGION_BASE, 2'b00});

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_operation = pfba_pkg::OP_ALLOC;
  logic [31:0]       in_frame_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       out_granted_address;
  logic [1:0]        out_status;
  logic [10:0]       out_free_frames;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_W-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                pending_results;
  int                mismatches;

  // stimulus bookkeeping
  logic [31:0] region_base = '0;
  int unsigned held_frames[$];
  logic        sent_ops[$];
  logic        tx_steady = 1'b0;
  logic        rx_steady = 1'b0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          full_hits = 0;
  int          range_hits = 0;
  int          settings_seen = 1;
  int          cycle_count = 0;

  physical_frame_bitmap_allocator_core #(
    .FRAMES    (FRAMES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_frame_address   (in_frame_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted_address(out_granted_address),
    .out_status         (out_status),
    .out_free_frames    (out_free_frames),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  pfba_reply_checker #(
    .FRAMES    (FRAMES),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_frame_address   (in_frame_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_granted_address(out_granted_address),
    .out_status         (out_status),
    .out_free_frames    (out_free_frames),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .pending_results    (pending_results),
    .mismatches         (mismatches)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d replies outstanding",
               cycle_count, pending_results);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Sink replies, remember granted frames for later frees, apply back-pressure
  always @(posedge clk) begin : reply_sink
    logic op;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready && sent_ops.size() > 0) begin
        op = sent_ops.pop_front();
        results_seen++;
        if (op == pfba_pkg::OP_ALLOC && out_status == pfba_pkg::STAT_OK) begin
          held_frames.push_back(int'((out_granted_address - region_base) >> PAGE_SHIFT));
        end
        if (out_status == pfba_pkg::STAT_NO_FREE) full_hits++;
        if (out_status == pfba_pkg::STAT_RANGE) range_hits++;
      end
      if (holds_done != holds_asked) begin
        hold_left  = HOLD_CYCLES;
        holds_done = holds_asked;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_steady || ($urandom_range(99) >= 33);
      end
    end
  end

  // Offer one request and hold it until the transfer
  task automatic issue_request(input logic op, input logic [31:0] addr);
    int gap;
    gap = 0;
    while (!tx_steady && $urandom_range(99) < 33) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_frame_address <= addr;
    do @(posedge clk); while (!in_ready);
    sent_ops.push_back(op);
    requests_sent++;
  endtask

  // Drop valid and wait until every reply is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // One register write: setup cycle, then access cycle
  task automatic write_cfg(input logic [CFG_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_region(input logic [31:0] value);
    wait_drained();
    write_cfg(REGION_BASE_ADDR, value);
    region_base = value;
    settings_seen++;
  endtask

  // Address inside the frame idx, with a random offset now and then
  function automatic logic [32:0] frame_address_of(input int unsigned idx);
    logic [32:0] offset;
    offset = ($urandom_range(3) == 0) ? 33'($urandom_range(PAGE_BYTES - 1)) : '0;
    return {1'b0, region_base} + 33'(idx << PAGE_SHIFT) + offset;
  endfunction

  // Mostly frames known to be in use; the rest any frame of the region, past or below it, or random addresses
  function automatic logic [31:0] pick_free_address();
    int unsigned pick;
    int unsigned pos;
    logic [32:0] target;
    pick = $urandom_range(99);
    if (pick < 70 && held_frames.size() > 0) begin
      pos    = $urandom_range(held_frames.size() - 1);
      target = frame_address_of(held_frames[pos]);
      // frames past the top of the address space stay held
      if (!target[32]) held_frames.delete(pos);
      return target[31:0];
    end
    if (pick < 80) begin
      target = frame_address_of($urandom_range(FRAMES - 1));
      return target[31:0];
    end
    if (pick < 88) return region_base + REGION_BYTES + $urandom_range(4 * PAGE_BYTES);
    if (pick < 94 && region_base != 0) return $urandom_range(region_base - 1);
    return $urandom;
  endfunction

  task automatic run_mix(input int count, input int alloc_pct);
    repeat (count) begin
      if ($urandom_range(99) < alloc_pct) issue_request(pfba_pkg::OP_ALLOC, $urandom);
      else issue_request(pfba_pkg::OP_FREE, pick_free_address());
    end
  endtask

  initial begin : stimulus
    int start_full;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // first fit, double free, unaligned and out-of-range frees at base zero
    issue_request(pfba_pkg::OP_ALLOC, 32'h0000_0000);
    issue_request(pfba_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    issue_request(pfba_pkg::OP_FREE, 32'(PAGE_BYTES));
    issue_request(pfba_pkg::OP_FREE, 32'(PAGE_BYTES));
    issue_request(pfba_pkg::OP_ALLOC, 32'h0000_0000);
    issue_request(pfba_pkg::OP_FREE, 32'(PAGE_BYTES - 1));
    issue_request(pfba_pkg::OP_FREE, REGION_BYTES - 1);
    issue_request(pfba_pkg::OP_FREE, REGION_BYTES);
    issue_request(pfba_pkg::OP_FREE, 32'hFFFF_FFFF);
    issue_request(pfba_pkg::OP_ALLOC, 32'h0000_0000);

    // below-base free and offset inside a frame at mid base
    set_region(32'h8000_0000);
    issue_request(pfba_pkg::OP_FREE, 32'h7FFF_FFFF);
    issue_request(pfba_pkg::OP_ALLOC, 32'h1234_5678);
    issue_request(pfba_pkg::OP_FREE, 32'h8000_0000 + 32'(2 * PAGE_BYTES) + 32'h0ABC);
    issue_request(pfba_pkg::OP_FREE, 32'h0000_0000);

    // unmapped register must not move the base; then a base that wraps
    wait_drained();
    write_cfg(SPARE_REG_ADDR, 32'hFFFF_FFFF);
    set_region(32'hFFFF_F000);
    issue_request(pfba_pkg::OP_ALLOC, 32'h0000_0000);
    issue_request(pfba_pkg::OP_FREE, 32'hFFFF_FFFF);
    issue_request(pfba_pkg::OP_FREE, 32'(PAGE_BYTES));
    issue_request(pfba_pkg::OP_ALLOC, 32'hFFFF_FFFF);

    // fill the map until it reports full a few times
    set_region(32'($urandom) & ~32'(PAGE_BYTES - 1));
    start_full = full_hits;
    while (full_hits < start_full + 3) issue_request(pfba_pkg::OP_ALLOC, $urandom);

    // drain the map back down; stall the reply side for a long stretch
    set_region(32'h0000_0000);
    run_mix(30, 30);
    holds_asked++;
    run_mix(70, 30);

    // region ending at the top of the address space, no idling anywhere
    set_region(32'hFFFF_FFFF - REGION_BYTES + 1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_mix(60, 50);
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // unaligned random base
    set_region($urandom);
    run_mix(40, 60);

    // highest base: almost every frame wraps past the address space
    set_region(32'hFFFF_FFFF);
    run_mix(20, 50);

    // lowest unaligned base, with a full pause halfway
    set_region(32'h0000_0001);
    run_mix(20, 45);
    wait_drained();
    run_mix(20, 45);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d requests over %0d region settings, %0d replies",
             requests_sent, settings_seen, results_seen);
    $display("tb: %0d replies found the map full, %0d frees fell outside the region",
             full_hits, range_hits);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pfba_pkg.sv
design/pfba_map_ram.sv
design/pfba_cfg_regs.sv
design/pfba_engine.sv
design/physical_frame_bitmap_allocator_core.sv
verif/pfba_reply_checker.sv
verif/tb.sv
